/* design/tabular_q_learning_agent_core_defines.svh */
// assertion helpers for the q-learning agent core
`ifndef TABULAR_Q_LEARNING_AGENT_CORE_DEFINES_SVH
`define TABULAR_Q_LEARNING_AGENT_CORE_DEFINES_SVH

// clocked property, held off while reset is asserted
`define TQLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define TQLA_ASSERT_IMP(label, ante, cons, msg) \
  `TQLA_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* design/tqla_pkg.sv */
`timescale 1ns / 1ps
package tqla_pkg;

  // value format and arithmetic widths
  localparam int Q_W     = 32;
  localparam int FRAC_W  = 16;
  localparam int MUL_A_W = 16;
  localparam int DIFF_W  = 34;
  localparam int PROD_W  = MUL_A_W + 1 + DIFF_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE    = 2'd2;

  localparam logic [15:0] LEARN_RATE_RST  = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST    = 16'd58982;
  localparam logic [6:0]  EXPLORE_PCT_RST = 7'd20;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_RD_OLD,
    S_MUL1,
    S_MUL2,
    S_WR,
    S_DONE
  } tqla_state_e;

endpackage

/* design/tqla_ram.sv */
`timescale 1ns / 1ps
module tqla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tqla_mul.sv */
`timescale 1ns / 1ps
module tqla_mul import tqla_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [MUL_A_W-1:0]       a_i,
  input  logic signed [DIFF_W-1:0] b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // unsigned fraction times signed operand, product registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= $signed({1'b0, a_i}) * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

/* design/tabular_q_learning_agent_core.sv */
`timescale 1ns / 1ps
// Tabular Q-learning agent with epsilon-greedy action choice.
// Input channel (in_valid_i / in_ready_o) carries the agent cell, the reward
// of the previous action and two random draws; output channel
// (out_valid_o / out_ready_i) returns one action and an explored flag per item.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once:
// index 0 learn rate, 1 discount, 2 explore percent; other indexes are dropped.
// After reset the value table is cleared by a pass over all
// NUM_ACTS*GRID_ROWS*GRID_COLS entries (1024 by default), in_ready_o low.
// The first item after reset skips the table update and returns action 0.
// Every later item runs the states S_RD, S_RD_OLD, S_MUL1, S_MUL2, S_WR and
// S_DONE, and no new item is taken until it returns to S_IDLE: the values of
// the cell are read one per cycle through the single table read port, then
// the shared multiplier runs twice and the updated value is written back.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and held at its end until the register frees.
module tabular_q_learning_agent_core import tqla_pkg::*; #(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 16,
  parameter int NUM_ACTS  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [3:0]            pos_row_i,
  input  logic [3:0]            pos_col_i,
  input  logic signed [7:0]     reward_i,
  input  logic [6:0]            explore_draw_i,
  input  logic [1:0]            random_action_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            action_o,
  output logic                  explored_o
);

`include "tabular_q_learning_agent_core_defines.svh"

  localparam int DEPTH = NUM_ACTS * GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int ACT_W = $clog2(NUM_ACTS);
  localparam int UPD_W = PROD_W - FRAC_W;

  tqla_state_e state_q, state_d;

  logic [AW-1:0]    clr_cnt_q;
  logic [ACT_W-1:0] rd_cnt_q;
  logic             rd_vld_q;
  logic [ACT_W-1:0] rd_act_q;

  logic [RW-1:0]    row_q, last_row_q;
  logic [CW-1:0]    col_q, last_col_q;
  logic [ACT_W-1:0] rnd_q, last_act_q, greedy_q;
  logic signed [7:0] reward_q;
  logic             explore_q;
  logic             first_q;
  logic             started_q;

  logic signed [Q_W-1:0] best_q, qmax_q, old_q;

  logic [15:0] learn_rate_q, discount_q;
  logic [6:0]  explore_pct_q;

  logic       out_valid_q;
  logic [1:0] action_q;
  logic       explored_q;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr, old_addr;
  logic [Q_W-1:0] ram_wdata, ram_rdata;

  logic                     mul_en;
  logic [MUL_A_W-1:0]       mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_prod;

  logic [31:0]      row_cl, col_cl, rnd_ext, rnd_mod;
  logic             explore_hit;
  logic             out_free;
  logic             rd_last;
  logic [ACT_W-1:0] act_res;

  logic signed [DIFF_W-1:0] reward_sh, old_ext, diff;
  logic signed [UPD_W-1:0]  upd;
  logic signed [Q_W-1:0]    upd_sat;
  logic signed [Q_W-1:0]    rd_val;

  function automatic logic [AW-1:0] cell_addr(input logic [ACT_W-1:0] a,
                                              input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'((32'(a) * GRID_ROWS + 32'(r)) * GRID_COLS + 32'(c));
  endfunction

  // ---------------------------------------------------------------------------
  // input conditioning at transfer
  always_comb begin
    row_cl  = (32'(pos_row_i) >= GRID_ROWS) ? 32'(GRID_ROWS - 1) : 32'(pos_row_i);
    col_cl  = (32'(pos_col_i) >= GRID_COLS) ? 32'(GRID_COLS - 1) : 32'(pos_col_i);
    rnd_ext = 32'(random_action_i);
    // draw is below 2*NUM_ACTS, so one subtract does the modulo
    rnd_mod = (rnd_ext >= NUM_ACTS) ? rnd_ext - 32'(NUM_ACTS) : rnd_ext;
    explore_hit = (({1'b0, explore_draw_i} + 8'd1) < {1'b0, explore_pct_q});
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_last  = (rd_cnt_q == ACT_W'(NUM_ACTS - 1));
  assign old_addr = cell_addr(last_act_q, last_row_q, last_col_q);
  assign act_res  = first_q ? '0 : (explore_q ? rnd_q : greedy_q);
  assign rd_val   = $signed(ram_rdata);

  // ---------------------------------------------------------------------------
  // update arithmetic around the shared multiplier
  always_comb begin
    reward_sh = $signed({{(DIFF_W - 8 - FRAC_W){reward_q[7]}}, reward_q,
                         {FRAC_W{1'b0}}});
    old_ext   = $signed({{(DIFF_W - Q_W){old_q[Q_W-1]}}, old_q});
    // first product is discount * qmax, floored by the arithmetic slice
    diff      = reward_sh + $signed(mul_prod[FRAC_W+DIFF_W-1:FRAC_W]) - old_ext;
    upd       = $signed({{(UPD_W - Q_W){old_q[Q_W-1]}}, old_q})
              + $signed(mul_prod[PROD_W-1:FRAC_W]);
    if ((upd[UPD_W-1:Q_W-1] == '0) || (upd[UPD_W-1:Q_W-1] == '1)) begin
      upd_sat = upd[Q_W-1:0];
    end else if (upd[UPD_W-1]) begin
      upd_sat = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      upd_sat = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = started_q ? S_RD : S_DONE;
      end
      S_RD: begin
        if (rd_last) state_d = S_RD_OLD;
      end
      S_RD_OLD: state_d = S_MUL1;
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_WR;
      S_WR:     state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = old_addr;
    ram_wdata  = upd_sat;
    ram_raddr  = old_addr;
    mul_en     = 1'b0;
    mul_a      = discount_q;
    mul_b      = $signed({{(DIFF_W - Q_W){qmax_q[Q_W-1]}}, qmax_q});
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      S_IDLE:   in_ready_o = 1'b1;
      S_RD:     ram_raddr = cell_addr(rd_cnt_q, row_q, col_q);
      S_RD_OLD: ram_raddr = old_addr;
      S_MUL1:   mul_en = 1'b1;
      S_MUL2: begin
        mul_en = 1'b1;
        mul_a  = learn_rate_q;
        mul_b  = diff;
      end
      S_WR:     ram_we = 1'b1;
      S_DONE:   ;
      default:  ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      started_q   <= 1'b0;
      last_row_q  <= '0;
      last_col_q  <= '0;
      last_act_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_RD);
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (state_q == S_RD) begin
        rd_cnt_q <= rd_last ? '0 : rd_cnt_q + ACT_W'(1);
      end
      if (in_valid_i && in_ready_o) begin
        started_q <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        last_row_q  <= row_q;
        last_col_q  <= col_q;
        last_act_q  <= act_res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q  <= LEARN_RATE_RST;
      discount_q    <= DISCOUNT_RST;
      explore_pct_q <= EXPLORE_PCT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEARN_RATE: learn_rate_q  <= cfg_wdata_i;
        CFG_DISCOUNT:   discount_q    <= cfg_wdata_i;
        CFG_EXPLORE:    explore_pct_q <= cfg_wdata_i[6:0];
        default:        ;
      endcase
    end
  end

  // item and search payload
  always_ff @(posedge clk_i) begin
    rd_act_q <= rd_cnt_q;
    if (in_valid_i && in_ready_o) begin
      row_q     <= RW'(row_cl);
      col_q     <= CW'(col_cl);
      reward_q  <= reward_i;
      explore_q <= explore_hit;
      rnd_q     <= ACT_W'(rnd_mod);
      first_q   <= !started_q;
      best_q    <= '0;
      greedy_q  <= '0;
    end
    // argmax from zero, strict compare keeps the lowest index on ties
    if (rd_vld_q) begin
      if (rd_act_q == '0) begin
        qmax_q <= rd_val;
      end
      if (rd_val > best_q) begin
        best_q   <= rd_val;
        qmax_q   <= rd_val;
        greedy_q <= rd_act_q;
      end
    end
    if (state_q == S_MUL1) begin
      old_q <= rd_val;
    end
    if (state_q == S_DONE && out_free) begin
      action_q   <= 2'(act_res);
      explored_q <= !first_q && explore_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign explored_o  = explored_q;

  // ---------------------------------------------------------------------------
  tqla_ram #(
    .WIDTH(Q_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tqla_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(mul_prod)
  );

  // ---------------------------------------------------------------------------
  `TQLA_ASSERT(a_first_item_short, (in_valid_i && in_ready_o && !started_q) |=> (state_q == S_DONE), "first item must skip the table update")
  `TQLA_ASSERT_IMP(a_clear_blocks_input, state_q == S_CLEAR, !in_ready_o, "input taken during clearing pass")
  `TQLA_ASSERT_IMP(a_explore_after_start, out_valid_o && explored_o, started_q, "explored result before first item")
  `TQLA_ASSERT_IMP(a_read_in_search, rd_vld_q, (state_q == S_RD) || (state_q == S_RD_OLD), "table read data outside the search")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import tqla_pkg::*;

  localparam int ACT_COUNT = 4;
  localparam int TABLE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint Q_HIGH = 64'sd2147483647;
  localparam longint Q_LOW  = -64'sd2147483648;

  typedef struct packed {
    logic [1:0] action;
    logic       explored;
  } step_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [3:0]            pos_row_i = '0;
  logic [3:0]            pos_col_i = '0;
  logic signed [7:0]     reward_i = '0;
  logic [6:0]            explore_draw_i = '0;
  logic [1:0]            random_action_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            action_o;
  logic                  explored_o;

  tabular_q_learning_agent_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pos_row_i      (pos_row_i),
    .pos_col_i      (pos_col_i),
    .reward_i       (reward_i),
    .explore_draw_i (explore_draw_i),
    .random_action_i(random_action_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .explored_o     (explored_o)
  );

  always #6 clk_i = ~clk_i;

  // agent mirror: value table, latched cell and action, registers
  logic signed [31:0] q_table [TABLE_DEPTH];
  logic [3:0]         prev_row = '0;
  logic [3:0]         prev_col = '0;
  logic [1:0]         prev_act = '0;
  bit                 has_started = 1'b0;
  logic [15:0]        alpha = LEARN_RATE_RST;
  logic [15:0]        gamma = DISCOUNT_RST;
  logic [6:0]         eps_pct = EXPLORE_PCT_RST;

  step_result_t pending_actions[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  // sender pacing
  int unsigned burst_left = 0;
  int unsigned next_gap = 0;
  bit          valid_held = 1'b0;

  // random walk inside a 4x4 box of cells
  int box_row = 0;
  int box_col = 0;
  int walk_row = 0;
  int walk_col = 0;

  // receiver stall pattern
  int unsigned rx_mode = 0;
  int unsigned rx_run = 0;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic predict_action(input logic [3:0] row, input logic [3:0] col,
                                input logic signed [7:0] rw, input logic [6:0] draw,
                                input logic [1:0] ra, output step_result_t res);
    logic [1:0]         greedy;
    logic signed [31:0] best;
    longint             qmax, tgt, old_q, upd, wide_a, wide_g, wide_r;
    int unsigned        draw_w, pct_w;
    if (!has_started) begin
      foreach (q_table[k]) q_table[k] = '0;
      has_started = 1'b1;
      prev_row = row;
      prev_col = col;
      prev_act = '0;
      res.action = '0;
      res.explored = 1'b0;
    end else begin
      // strict compare from zero: lowest index wins, action 0 if nothing positive
      greedy = '0;
      best = '0;
      for (int k = 0; k < ACT_COUNT; k++) begin
        if (q_table[{2'(k), row, col}] > best) begin
          best = q_table[{2'(k), row, col}];
          greedy = 2'(k);
        end
      end
      draw_w = draw;
      pct_w = eps_pct;
      res.explored = (draw_w + 1 < pct_w);
      res.action = res.explored ? ra : greedy;

      wide_a = alpha;
      wide_g = gamma;
      wide_r = rw;
      qmax = q_table[{greedy, row, col}];
      tgt = wide_r * 65536 + ((wide_g * qmax) >>> 16);
      old_q = q_table[{prev_act, prev_row, prev_col}];
      upd = old_q + ((wide_a * (tgt - old_q)) >>> 16);
      if (upd > Q_HIGH) upd = Q_HIGH;
      if (upd < Q_LOW) upd = Q_LOW;
      q_table[{prev_act, prev_row, prev_col}] = upd[31:0];

      prev_row = row;
      prev_col = col;
      prev_act = res.action;
    end
  endtask

  task automatic send_item(input logic [3:0] row, input logic [3:0] col,
                           input logic signed [7:0] rw, input logic [6:0] draw,
                           input logic [1:0] ra);
    step_result_t res;
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    pos_row_i <= row;
    pos_col_i <= col;
    reward_i <= rw;
    explore_draw_i <= draw;
    random_action_i <= ra;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_action(row, col, rw, draw, ra, res);
    pending_actions.push_back(res);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    end else begin
      burst_left--;
      next_gap = 0;
    end
    // keep valid up across back-to-back transfers
    if (next_gap != 0) in_valid_i <= 1'b0;
    valid_held = (next_gap == 0);
  endtask

  task automatic wait_drained();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_actions.size() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] lr, input logic [15:0] dc,
                            input logic [15:0] pct_word, input bit poke_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [15:0]          val [4];
    int                   n;
    idx = '{CFG_LEARN_RATE, CFG_DISCOUNT, CFG_EXPLORE, CFG_UNUSED};
    val = '{lr, dc, pct_word, 16'($urandom)};
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[k];
      cfg_wdata_i <= val[k];
      @(posedge clk_i);
      case (idx[k])
        CFG_LEARN_RATE: alpha = val[k];
        CFG_DISCOUNT:   gamma = val[k];
        CFG_EXPLORE:    eps_pct = val[k][6:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic place_box();
    box_row = $urandom_range(0, 12);
    box_col = $urandom_range(0, 12);
    walk_row = box_row;
    walk_col = box_col;
  endtask

  task automatic send_walk_item(input int rw_lo, input int rw_hi);
    int row, col, rw, draw;
    if ($urandom_range(0, 6) == 0) begin
      row = $urandom_range(0, 15);
      col = $urandom_range(0, 15);
    end else begin
      walk_row = walk_row + int'($urandom_range(0, 2)) - 1;
      walk_col = walk_col + int'($urandom_range(0, 2)) - 1;
      if (walk_row < box_row) walk_row = box_row;
      if (walk_row > box_row + 3) walk_row = box_row + 3;
      if (walk_col < box_col) walk_col = box_col;
      if (walk_col > box_col + 3) walk_col = box_col + 3;
      row = walk_row;
      col = walk_col;
    end
    case ($urandom_range(0, 19))
      0: rw = 127;
      1: rw = -128;
      default: rw = rw_lo + int'($urandom_range(0, rw_hi - rw_lo));
    endcase
    draw = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99);
    send_item(row[3:0], col[3:0], rw[7:0], draw[6:0], 2'($urandom_range(0, 3)));
  endtask

  // first transfer after reset: fields ignored, action 0
  task automatic test_first_item();
    send_item(4'd15, 4'd15, -8'sd128, 7'd0, 2'd3);
  endtask

  task automatic test_directed();
    send_item(4'd0, 4'd0, 8'sd127, 7'd127, 2'd0);
    send_item(4'd0, 4'd0, -8'sd128, 7'd0, 2'd3);
    send_item(4'd15, 4'd0, 8'sd0, 7'd18, 2'd1);    // last draw that explores
    send_item(4'd0, 4'd15, 8'sd5, 7'd19, 2'd2);    // first draw that exploits
    send_item(4'd15, 4'd15, 8'sd127, 7'd99, 2'd2);
    send_item(4'd15, 4'd15, 8'sd127, 7'd99, 2'd1);
    send_item(4'd15, 4'd15, -8'sd1, 7'd64, 2'd0);
    send_item(4'd7, 4'd8, -8'sd128, 7'd42, 2'd3);
    send_item(4'd8, 4'd7, 8'sd1, 7'd0, 2'd0);
    send_item(4'd8, 4'd7, 8'sd127, 7'd0, 2'd1);
    send_item(4'd8, 4'd7, 8'sd127, 7'd0, 2'd2);
    send_item(4'd8, 4'd7, 8'sd127, 7'd0, 2'd3);
    send_item(4'd8, 4'd7, 8'sd0, 7'd50, 2'd0);     // greedy among learned values
    send_item(4'd8, 4'd7, 8'sd0, 7'd85, 2'd0);
    send_item(4'd10, 4'd5, -8'sd128, 7'd99, 2'd0);
    send_item(4'd10, 4'd5, -8'sd128, 7'd99, 2'd0); // nothing positive
    send_item(4'd10, 4'd5, 8'sd100, 7'd85, 2'd2);
    send_item(4'd4, 4'd11, -8'sd64, 7'd3, 2'd1);
    send_item(4'd11, 4'd4, 8'sd63, 7'd100, 2'd3);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(16'd0, 16'd0, 16'd0, 1'b0);
        1: set_config(16'hFFFF, 16'hFFFF, 16'd100, 1'b0);
        2: set_config(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);   // explore field saturated
        3: set_config(16'd1, 16'd1, 16'd1, 1'b1);
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 100)), 1'b1);
      endcase
      place_box();
      for (int k = 0; k < 140; k++) send_walk_item(-4, 10);
      wait_drained();
    end
  endtask

  // one cell at a time, one action: the value runs into both rails
  task automatic test_saturation();
    set_config(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    for (int k = 0; k < 320; k++)
      send_item(4'd3, 4'd5, 8'sd127, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
    for (int k = 0; k < 320; k++)
      send_item(4'd9, 4'd12, -8'sd128, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
    wait_drained();
  endtask

  task automatic test_random_walk();
    set_config(LEARN_RATE_RST, DISCOUNT_RST, 16'(EXPLORE_PCT_RST), 1'b0);
    for (int k = 0; k < 400; k++) begin
      if (k % 50 == 0) place_box();
      // sender holds off until everything is back
      if (k % 130 == 129) wait_drained();
      send_walk_item(-10, 20);
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (rx_run == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_run <= $urandom_range(50, 300);
    end else begin
      rx_run <= rx_run - 1;
    end
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= ((rx_run % 16) < 11);
    endcase
  end

  always @(posedge clk_i) begin
    step_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected result action %0d explored %0b",
                                  action_o, explored_o));
      end else begin
        exp_r = pending_actions.pop_front();
        if (action_o !== exp_r.action)
          report_mismatch($sformatf("action %0d, want %0d", action_o, exp_r.action));
        if (explored_o !== exp_r.explored)
          report_mismatch($sformatf("explored %0b, want %0b", explored_o, exp_r.explored));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_first_item();
    test_directed();
    test_config_sweep();
    test_saturation();
    test_random_walk();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_actions.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_actions.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* tabular_q_learning_agent_core.f */
+incdir+design
design/tqla_pkg.sv
design/tqla_ram.sv
design/tqla_mul.sv
design/tabular_q_learning_agent_core.sv
tb/tb.sv
